FILE: hw/rtl/cfpid_pkg.sv
package cfpid_pkg;

	// Result codes carried in the status field.
	typedef enum logic [1:0] {
		ST_PASS = 2'd0,
		ST_THIN = 2'd1,
		ST_BAD  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// Width of the slot number carried along the cell chain. It covers the
	// deepest table that the top level supports.
	localparam int TOK_SLOT_W = 10;

	localparam logic [28:0] OBD_REPLY_LO = 29'h7e8;
	localparam logic [28:0] OBD_REPLY_HI = 29'h7ef;
	localparam int          PID_SHIFT    = 16;
	localparam int          MS_PER_SEC   = 1000;
	localparam logic [9:0]  STEP_MIN     = 10'd100;
	localparam logic [9:0]  STEP_MAX     = 10'd1000;
	localparam logic [9:0]  MSEC_MAX     = 10'd999;
	localparam logic [19:0] USEC_MAX     = 20'd999999;

	// usec / 1000 as (usec * MSEC_RECIP) >> MSEC_SHIFT, exact for usec below 2^20.
	localparam logic [20:0] MSEC_RECIP = 21'd1073742;
	localparam int          MSEC_SHIFT = 30;

	typedef struct packed {
		logic [1:0]  bus;
		logic [28:0] can_id;
		logic [3:0]  length;
		logic [63:0] payload;
		logic [31:0] stamp_sec;
		logic [19:0] stamp_usec;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic [5:0]         slot;
		logic [31:0]        stream_key;
		logic signed [31:0] rel_sec;
		logic [9:0]         rel_msec;
	} out_item_t;

	// Search token handed from cell to cell.
	typedef struct packed {
		logic                  active;
		logic                  hit;
		logic [TOK_SLOT_W-1:0] slot;
		logic [31:0]           sec;
		logic [9:0]            msec;
	} tok_t;

	// Write command broadcast to the cells.
	typedef struct packed {
		logic                  key_we;
		logic                  time_we;
		logic [TOK_SLOT_W-1:0] slot;
		logic [31:0]           sec;
		logic [9:0]            msec;
	} wr_t;

endpackage

FILE: hw/rtl/cfpid_cell.sv
module cfpid_cell import cfpid_pkg::*; #(
	parameter int ENTRY_W = 34,
	parameter int USED_W  = 7,
	parameter int IDX     = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ENTRY_W-1:0] probe_key,
	input  logic [USED_W-1:0]  used,
	input  tok_t               tok_in,
	output tok_t               tok_out,
	input  wr_t                wr,
	input  logic [ENTRY_W-1:0] wr_key
);

	logic [ENTRY_W-1:0]    key_q;
	logic [31:0]           sec_q;
	logic [9:0]            msec_q;
	logic                  active_q;
	logic                  hit_q;
	logic [TOK_SLOT_W-1:0] slot_q;
	logic [31:0]           tok_sec_q;
	logic [9:0]            tok_msec_q;
	logic                  sel;
	logic                  hit;

	assign sel = (wr.slot == TOK_SLOT_W'(IDX));
	// The cell holds a stream only once the fill count has passed it.
	assign hit = tok_in.active && (32'(used) > 32'(IDX)) && (key_q == probe_key);

	always_ff @(posedge clk) begin
		if (wr.key_we && sel) begin
			key_q <= wr_key;
		end
		if (wr.time_we && sel) begin
			sec_q  <= wr.sec;
			msec_q <= wr.msec;
		end
		if (hit) begin
			hit_q      <= 1'b1;
			slot_q     <= TOK_SLOT_W'(IDX);
			tok_sec_q  <= sec_q;
			tok_msec_q <= msec_q;
		end else begin
			hit_q      <= tok_in.hit;
			slot_q     <= tok_in.slot;
			tok_sec_q  <= tok_in.sec;
			tok_msec_q <= tok_in.msec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else begin
			active_q <= tok_in.active;
		end
	end

	// Fields in the order of the token type.
	assign tok_out = {active_q, hit_q, slot_q, tok_sec_q, tok_msec_q};

endmodule

FILE: hw/rtl/can_frame_per_id_decimator.sv
// Per-stream CAN frame decimator.
//
// Frames enter on the in_item channel (in_valid / in_stall) and each one
// produces exactly one result transfer on the out_item channel (out_valid /
// out_stall). The result tells whether the frame passed, was thinned out,
// had a bad length or found the stream table full, together with its slot,
// stream key and time relative to the first frame seen.
// The step between passed frames of one stream is written on the cfg
// channel (cfg_valid / cfg_ready, always ready); it should only be changed
// while no frame is in flight.
// One frame is handled at a time. A frame of a known stream passes the
// prepare, search, difference, compare and emit states before out_valid, a
// new stream or a full table prepare, search and emit, and a bad length
// prepare and emit. The next frame is taken once the result has entered the
// output register. The time per frame is set by the search token, which
// walks the row of table cells one cell per cycle.
// When the receiver stalls, the finished result waits in the output
// register while the next frame is already accepted and searched; that
// frame then waits for the register to drain before it is delivered.
// Reset empties the table, forgets the time origin, sets the step to
// 1000 ms and drops any frame or result in flight.
module can_frame_per_id_decimator import cfpid_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int BUS_COUNT   = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [9:0] cfg_data
);

	localparam int BUS_W   = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
	localparam int ENTRY_W = BUS_W + 32;
	localparam int USED_W  = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SEARCH,
		S_DIFF,
		S_CMP,
		S_EMIT
	} state_t;

	state_t      state_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic [31:0] origin_q;
	logic        origin_set_q;
	logic [USED_W-1:0] used_q;
	logic [9:0]  step_q;

	// Frame under work.
	logic [ENTRY_W-1:0] entry_q;
	logic               bad_q;
	logic [31:0]        sec_q;
	logic [19:0]        usec_q;
	logic [31:0]        rsec_q;
	logic [9:0]         msec_q;
	logic [TOK_SLOT_W-1:0] hslot_q;
	logic [31:0]        hsec_q;
	logic [9:0]         hmsec_q;
	logic signed [42:0] prod_q;
	out_item_t          res_q;

	logic               accept;
	logic               out_free;
	logic [31:0]        key_c;
	logic [31:0]        bus_c;
	logic [ENTRY_W-1:0] entry_c;
	logic [40:0]        recip_c;
	logic [9:0]         msec_c;
	logic [31:0]        rsec_c;
	logic signed [32:0] dsec_c;
	logic signed [10:0] dmsec_c;
	logic signed [42:0] delta_c;
	logic signed [42:0] step_c;
	logic               pass_c;
	logic               full_c;
	logic [TOK_SLOT_W-1:0] ins_slot_c;
	tok_t               tok [TABLE_DEPTH+1];
	tok_t               tok_end;
	wr_t                wr;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign cfg_ready = 1'b1;

	// Stream key: OBD-II replies carry their PID in bits 23..16, and a short
	// reply contributes no PID at all.
	always_comb begin
		key_c = {3'b000, in_item.can_id};
		if (in_item.can_id inside {[OBD_REPLY_LO:OBD_REPLY_HI]}) begin
			if (in_item.length >= 4'd3) begin
				key_c = key_c | (32'(in_item.payload[23:16]) << PID_SHIFT);
			end
		end
		// Buses beyond the configured count fold onto the last one.
		if (32'(in_item.bus) >= 32'(BUS_COUNT)) begin
			bus_c = 32'(BUS_COUNT - 1);
		end else begin
			bus_c = 32'(in_item.bus);
		end
		entry_c = {bus_c[BUS_W-1:0], key_c};
	end

	// Milliseconds by reciprocal multiplication, and seconds from the origin.
	always_comb begin
		recip_c = 41'(usec_q) * 41'(MSEC_RECIP);
		if (usec_q > USEC_MAX) begin
			msec_c = MSEC_MAX;
		end else begin
			msec_c = recip_c[MSEC_SHIFT +: 10];
		end
		rsec_c = sec_q - origin_q;
	end

	// Interval against the last passed frame of the stream, in signed
	// milliseconds. The seconds difference is scaled one state earlier.
	always_comb begin
		dsec_c  = $signed({rsec_q[31], rsec_q}) - $signed({hsec_q[31], hsec_q});
		dmsec_c = $signed({1'b0, msec_q}) - $signed({1'b0, hmsec_q});
		delta_c = prod_q + 43'(dmsec_c);
		if (step_q < STEP_MIN || step_q > STEP_MAX) begin
			step_c = $signed(43'(STEP_MAX));
		end else begin
			step_c = $signed(43'(step_q));
		end
		pass_c = (delta_c >= step_c);
	end

	assign full_c     = (used_q == USED_W'(TABLE_DEPTH));
	assign ins_slot_c = TOK_SLOT_W'(used_q);
	assign tok_end    = tok[TABLE_DEPTH];

	// Token launched into the first cell while the frame is prepared.
	always_comb begin
		tok[0]        = '0;
		tok[0].active = (state_q == S_PREP) && !bad_q;
	end

	// Writes into the cells: a new stream takes the next free cell, and a
	// passed frame refreshes the time of its stream.
	always_comb begin
		wr      = '0;
		wr.sec  = rsec_q;
		wr.msec = msec_q;
		if (state_q == S_SEARCH && tok_end.active && !tok_end.hit && !full_c) begin
			wr.key_we  = 1'b1;
			wr.time_we = 1'b1;
			wr.slot    = ins_slot_c;
		end else if (state_q == S_CMP) begin
			wr.time_we = pass_c;
			wr.slot    = hslot_q;
		end
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		cfpid_cell #(
			.ENTRY_W(ENTRY_W),
			.USED_W (USED_W),
			.IDX    (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.probe_key(entry_q),
			.used     (used_q),
			.tok_in   (tok[g]),
			.tok_out  (tok[g+1]),
			.wr       (wr),
			.wr_key   (entry_q)
		);
	end

	// Sequencer, output register and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			origin_q     <= '0;
			origin_set_q <= 1'b0;
			used_q       <= '0;
			step_q       <= STEP_MAX;
		end else begin
			if (cfg_valid) begin
				step_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						// Every frame, even a rejected one, may set the origin.
						if (!origin_set_q) begin
							origin_q     <= in_item.stamp_sec;
							origin_set_q <= 1'b1;
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= bad_q ? S_EMIT : S_SEARCH;
				end
				S_SEARCH: begin
					if (tok_end.active) begin
						if (tok_end.hit) begin
							state_q <= S_DIFF;
						end else begin
							if (!full_c) begin
								used_q <= used_q + USED_W'(1);
							end
							state_q <= S_EMIT;
						end
					end
				end
				S_DIFF: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Frame data and intermediate results.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					entry_q <= entry_c;
					bad_q   <= (in_item.length == 4'd0) || (in_item.length > 4'd8);
					sec_q   <= in_item.stamp_sec;
					usec_q  <= in_item.stamp_usec;
				end
			end
			S_PREP: begin
				rsec_q <= rsec_c;
				msec_q <= msec_c;
				res_q.status     <= ST_BAD;
				res_q.slot       <= '0;
				res_q.stream_key <= '0;
				res_q.rel_sec    <= $signed(rsec_c);
				res_q.rel_msec   <= msec_c;
			end
			S_SEARCH: begin
				hslot_q <= tok_end.slot;
				hsec_q  <= tok_end.sec;
				hmsec_q <= tok_end.msec;
				res_q.stream_key <= entry_q[31:0];
				if (full_c) begin
					res_q.status <= ST_FULL;
					res_q.slot   <= '0;
				end else begin
					res_q.status <= ST_PASS;
					res_q.slot   <= ins_slot_c[5:0];
				end
			end
			S_DIFF: begin
				// Times 1000, taken as 1024 - 32 + 8.
				prod_q <= (43'(dsec_c) <<< 10) - (43'(dsec_c) <<< 5) + (43'(dsec_c) <<< 3);
			end
			S_CMP: begin
				res_q.status <= pass_c ? ST_PASS : ST_THIN;
				res_q.slot   <= hslot_q[5:0];
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/cfpid_checker.sv
module cfpid_checker import cfpid_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item,
	input logic      cfg_valid,
	input logic      cfg_ready,
	input logic [9:0] cfg_data
);

	// A frame is worked on alone, so the input closes right after a transfer.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted a second frame while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed or vanished");

	a_bad_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_BAD
		|-> out_item.slot == 6'd0 && out_item.stream_key == 32'd0)
		else $error("bad length result carries a slot or key");

	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_FULL |-> out_item.slot == 6'd0)
		else $error("table full result carries a slot");

	a_msec_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.rel_msec <= MSEC_MAX)
		else $error("milliseconds out of range");

endmodule

bind can_frame_per_id_decimator cfpid_checker u_cfpid_checker (.*);
